// ===== rtl/stg_pkg.sv =====
package stg_pkg;

  // field and register widths
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned SPD_W       = 17;
  localparam int unsigned NOW_W       = 16;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned IN_USER_W   = 1;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned TIMER_BITS_DEF = 16;

  // shared divider: 33 bit dividend, 16 bit divisor
  localparam int unsigned DIV_DW = 33;
  localparam int unsigned DIV_VW = 16;

  // register reset values
  localparam logic [CFG_W-1:0] ACCEL_RST    = 16'd1;
  localparam logic [CFG_W-1:0] MAX_SPD_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] HIGH_RST     = 16'd10;
  localparam logic [CFG_W-1:0] EXTRA_RST    = 16'd10;
  localparam logic [CFG_W-1:0] MAX_LOW_RST  = 16'hFFFF;
  localparam logic             REVERSE_RST  = 1'b0;

  typedef enum logic [2:0] {
    REG_ACCEL     = 3'd0,
    REG_MAX_SPEED = 3'd1,
    REG_HIGH      = 3'd2,
    REG_EXTRA     = 3'd3,
    REG_MAX_LOW   = 3'd4,
    REG_REVERSE   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] accel_step;
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] pulse_high_time;
    logic [CFG_W-1:0] extra_low_time;
    logic [CFG_W-1:0] max_low_time;
    logic             reverse_direction;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_STOP,
    ST_PULSE,
    ST_MUL,
    ST_DIV_LOW_GO,
    ST_DIV_LOW,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2,
    PH_UNUSED = 2'd3
  } phase_e;

endpackage

// ===== rtl/stepper_trapezoid_step_generator_core.sv =====
// sequence: a poll at rest on target goes eval, finish; a plain poll eval, pulse,
//   finish; a stop distance divide sits between eval and pulse, a low time divide
//   after mul between pulse and finish; one poll at a time, the shared 33-step
//   restoring divider, tready returns once the result is in the output register
// reset: position, speed and pulse state clear to zero, registers take their
//   default values
module stepper_trapezoid_step_generator_core #(
  parameter int unsigned TIMER_BITS = stg_pkg::TIMER_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // apb configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [stg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [stg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  // poll stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: now_ticks[15:0], target_position[47:16]
  input  logic [stg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: zero_position[0]
  input  logic [stg_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: dir_level[0], step_level[1], position[33:2], speed[50:34],
  //        arrived[51], zero fill[55:52]
  output logic [stg_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned TW    = TIMER_BITS;
  localparam int unsigned PW    = stg_pkg::POS_W;
  localparam int unsigned SW    = stg_pkg::SPD_W;
  localparam int unsigned CW    = stg_pkg::CFG_W;
  localparam int unsigned DW    = stg_pkg::DIV_DW;

  stg_pkg::cfg_t     cfg;
  stg_pkg::div_req_t div_req;
  stg_pkg::div_rsp_t div_rsp;

  stg_pkg::state_e   state_q, state_d;
  stg_pkg::phase_e   phase_q, phase_d;
  logic signed [PW-1:0] pos_q, pos_d;
  logic signed [SW-1:0] speed_q, speed_d;
  logic              active_q, active_d;
  logic [TW-1:0]     stamp_q, stamp_d;
  logic [CW-1:0]     low_q, low_d;
  logic              dir_q, dir_d;
  logic              step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [stg_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [stg_pkg::NOW_W-1:0] now_q;
  logic signed [PW-1:0]      target_q;
  logic [DW-1:0]             prod_q;
  logic                      load_prod;

  logic                      accept;

  stg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  stg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == stg_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // effective acceleration, zero acts as one
  logic [CW-1:0] a_eff;
  assign a_eff = (cfg.accel_step == '0) ? CW'(1) : cfg.accel_step;

  // distance to target and its magnitude
  logic signed [PW:0] delta;
  logic [PW:0]        dist_mag;
  logic               d_zero, d_neg, d_pos;
  assign delta    = {target_q[PW-1], target_q} - {pos_q[PW-1], pos_q};
  assign dist_mag = delta[PW] ? (PW+1)'(-delta) : delta;
  assign d_zero   = (delta == '0);
  assign d_neg    = delta[PW];
  assign d_pos    = !d_zero && !d_neg;

  // speed sign and magnitude
  logic               s_zero, s_neg, s_pos;
  logic signed [SW-1:0] speed_neg;
  logic [CW-1:0]      s_mag;
  assign s_zero    = (speed_q == '0);
  assign s_neg     = speed_q[SW-1];
  assign s_pos     = !s_zero && !s_neg;
  assign speed_neg = -speed_q;
  assign s_mag     = s_neg ? speed_neg[CW-1:0] : speed_q[CW-1:0];

  // accelerate and decelerate candidates
  logic signed [SW+1:0] s_ext, a_ext, mx_ext, sum_up, sum_dn, up_val, slow_val;
  assign s_ext  = {{2{speed_q[SW-1]}}, speed_q};
  assign a_ext  = signed'({3'b000, a_eff});
  assign mx_ext = signed'({3'b000, cfg.max_speed});
  assign sum_up = s_ext + a_ext;
  assign sum_dn = s_ext - a_ext;

  always_comb begin
    if (d_pos) begin
      up_val = (sum_up > mx_ext) ? mx_ext : sum_up;
    end else begin
      up_val = (sum_dn < -mx_ext) ? -mx_ext : sum_dn;
    end
    if (s_pos) begin
      slow_val = (sum_dn < 0) ? '0 : sum_dn;
    end else begin
      slow_val = (sum_up > 0) ? '0 : sum_up;
    end
  end

  // stop distance against remaining distance
  logic toward, stop_too_far;
  assign toward       = (!s_neg && d_pos) || (!s_pos && d_neg);
  assign stop_too_far = {16'b0, div_rsp.quotient[SW-1:0]} >= dist_mag;

  // elapsed timer ticks
  logic [31:0]   now32;
  logic [TW-1:0] now_t;
  logic [TW-1:0] elapsed;
  logic [31:0]   el32;
  assign now32   = {16'b0, now_q};
  assign now_t   = now32[TW-1:0];
  assign elapsed = now_t - stamp_q;
  assign el32    = 32'(elapsed);

  // low time product, registered before the divide
  logic [SW-1:0] lt_sum;
  logic [DW-1:0] prod_w;
  assign lt_sum = {1'b0, cfg.extra_low_time} + {1'b0, cfg.pulse_high_time};
  assign prod_w = lt_sum * cfg.max_speed;

  // low time from quotient: subtract high time, saturate, cap
  logic [DW-1:0] high_ext, lt_full;
  logic [CW-1:0] lt_cap;
  assign high_ext = {17'b0, cfg.pulse_high_time};
  assign lt_full  = (div_rsp.quotient > high_ext) ? div_rsp.quotient - high_ext : '0;
  assign lt_cap   = (lt_full > {17'b0, cfg.max_low_time}) ? cfg.max_low_time
                                                          : lt_full[CW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    speed_d     = speed_q;
    active_d    = active_q;
    stamp_d     = stamp_q;
    low_d       = low_q;
    dir_d       = dir_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    load_prod   = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {17'b0, s_mag - CW'(1)};
    div_req.divisor  = a_eff;

    case (state_q)
      stg_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser[0]) begin
            pos_d = '0;
          end
          state_d = stg_pkg::ST_EVAL;
        end
      end

      stg_pkg::ST_EVAL: begin
        if (s_zero && d_zero) begin
          state_d = stg_pkg::ST_FINISH;
        end else if (active_q) begin
          state_d = stg_pkg::ST_PULSE;
        end else if (toward && !s_zero) begin
          div_req.start = 1'b1;
          state_d       = stg_pkg::ST_DIV_STOP;
        end else begin
          speed_d  = toward ? up_val[SW-1:0] : slow_val[SW-1:0];
          active_d = 1'b1;
          state_d  = stg_pkg::ST_PULSE;
        end
      end

      stg_pkg::ST_DIV_STOP: begin
        if (div_rsp.done) begin
          speed_d  = stop_too_far ? slow_val[SW-1:0] : up_val[SW-1:0];
          active_d = 1'b1;
          state_d  = stg_pkg::ST_PULSE;
        end
      end

      stg_pkg::ST_PULSE: begin
        state_d = stg_pkg::ST_FINISH;
        if (s_zero) begin
          active_d = 1'b0;
        end else begin
          case (phase_q)
            stg_pkg::PH_IDLE: begin
              stamp_d = now_t;
              phase_d = stg_pkg::PH_HIGH;
              dir_d   = s_pos ^ cfg.reverse_direction;
              step_d  = 1'b1;
            end
            stg_pkg::PH_HIGH: begin
              if (el32 > {16'b0, cfg.pulse_high_time}) begin
                state_d = stg_pkg::ST_MUL;
              end
            end
            stg_pkg::PH_LOW: begin
              if (el32 > {16'b0, low_q}) begin
                pos_d    = s_pos ? pos_q + 1 : pos_q - 1;
                phase_d  = stg_pkg::PH_IDLE;
                active_d = 1'b0;
              end
            end
            default: begin
              phase_d  = stg_pkg::PH_IDLE;
              step_d   = 1'b0;
              active_d = 1'b0;
            end
          endcase
        end
      end

      stg_pkg::ST_MUL: begin
        load_prod = 1'b1;
        state_d   = stg_pkg::ST_DIV_LOW_GO;
      end

      stg_pkg::ST_DIV_LOW_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = s_mag;
        state_d          = stg_pkg::ST_DIV_LOW;
      end

      stg_pkg::ST_DIV_LOW: begin
        if (div_rsp.done) begin
          stamp_d = now_t;
          phase_d = stg_pkg::PH_LOW;
          step_d  = 1'b0;
          low_d   = lt_cap;
          state_d = stg_pkg::ST_FINISH;
        end
      end

      stg_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0000, (s_zero && (pos_q == target_q)), speed_q, pos_q,
                         step_q, dir_q};
          state_d     = stg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = stg_pkg::ST_IDLE;
      end
    endcase
  end

  // control and motion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stg_pkg::ST_IDLE;
      phase_q     <= stg_pkg::PH_IDLE;
      pos_q       <= '0;
      speed_q     <= '0;
      active_q    <= 1'b0;
      stamp_q     <= '0;
      low_q       <= '0;
      dir_q       <= 1'b0;
      step_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      speed_q     <= speed_d;
      active_q    <= active_d;
      stamp_q     <= stamp_d;
      low_q       <= low_d;
      dir_q       <= dir_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // poll word, product and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q    <= s_axis_tdata[stg_pkg::NOW_W-1:0];
      target_q <= signed'(s_axis_tdata[stg_pkg::NOW_W +: PW]);
    end
    if (load_prod) begin
      prod_q <= prod_w;
    end
    out_data_q <= out_data_d;
  end

  // a pulse in progress always keeps the block marked active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != stg_pkg::PH_IDLE) |-> active_q)
    else $error("pulse phase set while pulse inactive");

  // divider results only arrive while a divide is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == stg_pkg::ST_DIV_STOP || state_q == stg_pkg::ST_DIV_LOW))
    else $error("divider finished outside a divide state");

  // an accepted poll blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("poll accepted while previous poll in progress");

endmodule

// ===== rtl/stg_regs.sv =====
module stg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [stg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [stg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output stg_pkg::cfg_t                    cfg_o
);

  stg_pkg::cfg_t    cfg_q;
  stg_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = stg_pkg::reg_idx_e'(paddr[stg_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step        <= stg_pkg::ACCEL_RST;
      cfg_q.max_speed         <= stg_pkg::MAX_SPD_RST;
      cfg_q.pulse_high_time   <= stg_pkg::HIGH_RST;
      cfg_q.extra_low_time    <= stg_pkg::EXTRA_RST;
      cfg_q.max_low_time      <= stg_pkg::MAX_LOW_RST;
      cfg_q.reverse_direction <= stg_pkg::REVERSE_RST;
    end else if (wr_en) begin
      case (idx)
        stg_pkg::REG_ACCEL:     cfg_q.accel_step        <= pwdata[stg_pkg::CFG_W-1:0];
        stg_pkg::REG_MAX_SPEED: cfg_q.max_speed         <= pwdata[stg_pkg::CFG_W-1:0];
        stg_pkg::REG_HIGH:      cfg_q.pulse_high_time   <= pwdata[stg_pkg::CFG_W-1:0];
        stg_pkg::REG_EXTRA:     cfg_q.extra_low_time    <= pwdata[stg_pkg::CFG_W-1:0];
        stg_pkg::REG_MAX_LOW:   cfg_q.max_low_time      <= pwdata[stg_pkg::CFG_W-1:0];
        stg_pkg::REG_REVERSE:   cfg_q.reverse_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (idx)
      stg_pkg::REG_ACCEL:     prdata = 32'(cfg_q.accel_step);
      stg_pkg::REG_MAX_SPEED: prdata = 32'(cfg_q.max_speed);
      stg_pkg::REG_HIGH:      prdata = 32'(cfg_q.pulse_high_time);
      stg_pkg::REG_EXTRA:     prdata = 32'(cfg_q.extra_low_time);
      stg_pkg::REG_MAX_LOW:   prdata = 32'(cfg_q.max_low_time);
      stg_pkg::REG_REVERSE:   prdata = 32'(cfg_q.reverse_direction);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== rtl/stg_div.sv =====
module stg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stg_pkg::div_req_t req_i,
  output stg_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW    = stg_pkg::DIV_DW;
  localparam int unsigned VW    = stg_pkg::DIV_VW;
  localparam int unsigned CNT_W = $clog2(DW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [VW-1:0]    rem_q;
  logic [VW-1:0]    dvs_q;
  logic [DW-1:0]    quo_q;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

endmodule

// ===== bench/stepper_trapezoid_step_generator_core_tb.sv =====
`timescale 1ns / 1ps
module stepper_trapezoid_step_generator_core_tb;
  import stg_pkg::*;

  // result word, packed to match m_axis_tdata[51:0]
  typedef struct packed {
    logic               arrived;
    logic signed [16:0] speed;
    logic signed [31:0] position;
    logic               step;
    logic               dir;
  } motion_t;

  // directed poll, with a hand-typed result where one is given
  typedef struct packed {
    logic [15:0]        now;
    logic signed [31:0] target;
    logic               zero;
    logic               typed;
    motion_t            res;
  } poll_row_t;

  localparam int N_ROWS       = 21;
  localparam int N_PHASES     = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // bench bookkeeping
  motion_t   pending_motion[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        stall_on = 1'b1;
  poll_row_t poll_rows [N_ROWS];
  cfg_t      phase_cfg [N_PHASES];
  int        phase_len [N_PHASES];

  // motion state as the block should hold it
  cfg_t               cfg_m;
  logic signed [31:0] pos_m = '0;
  logic signed [16:0] spd_m = '0;
  logic               busy_m = 1'b0;
  phase_e             phase_m = PH_IDLE;
  logic [15:0]        stamp_m = '0;
  logic [15:0]        low_m = '0;
  logic               dir_m = 1'b0;
  logic               step_m = 1'b0;

  stepper_trapezoid_step_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // accel_step of zero behaves as one
  function automatic longint accel_eff();
    return (cfg_m.accel_step == 0) ? 64'sd1 : longint'(cfg_m.accel_step);
  endfunction

  // steps needed to brake from speed s: ceil(|s|/a) - 1
  function automatic longint stop_steps(input longint s);
    longint a, m;
    a = accel_eff();
    m = (s < 0) ? -s : s;
    return m / a + (((m % a) != 0) ? 64'sd0 : -64'sd1);
  endfunction

  function automatic longint slow_by_one(input longint s);
    longint a;
    a = accel_eff();
    if (s > 0) begin
      s = s - a;
      if (s < 0) s = 0;
    end else begin
      s = s + a;
      if (s > 0) s = 0;
    end
    return s;
  endfunction

  function automatic longint speed_toward(input longint s, input longint delta);
    longint a, mx;
    a = accel_eff();
    mx = longint'(cfg_m.max_speed);
    if (s > 0 || (s == 0 && delta > 0)) begin
      s = s + a;
      if (s > mx) s = mx;
    end else begin
      s = s - a;
      if (s < -mx) s = -mx;
    end
    return s;
  endfunction

  // one poll: speed decision between pulses, then the pulse sequencer
  function automatic motion_t advance_motion(input logic [15:0] now,
                                             input logic signed [31:0] tgt,
                                             input logic zero);
    longint  delta, s, a, mag, q, lt;
    motion_t r;
    if (zero) pos_m = '0;
    delta = longint'(tgt) - longint'(pos_m);
    s = longint'(spd_m);
    a = accel_eff();
    if (!(s == 0 && delta == 0)) begin
      if (!busy_m) begin
        if (s >= 0 && delta > 0) begin
          if (stop_steps(s) >= delta) s = slow_by_one(s);
          else if (stop_steps(s + a) <= delta) s = speed_toward(s, delta);
        end else if (s <= 0 && delta < 0) begin
          if (stop_steps(s) >= -delta) s = slow_by_one(s);
          else if (stop_steps(s - a) <= -delta) s = speed_toward(s, delta);
        end else begin
          // target behind the motion
          s = slow_by_one(s);
        end
        spd_m = 17'(s);
        busy_m = 1'b1;
      end
      if (spd_m == 0) begin
        busy_m = 1'b0;
      end else begin
        case (phase_m)
          PH_IDLE: begin
            stamp_m = now;
            phase_m = PH_HIGH;
            dir_m = (spd_m > 0) ^ cfg_m.reverse_direction;
            step_m = 1'b1;
          end
          PH_HIGH: begin
            if (16'(now - stamp_m) > cfg_m.pulse_high_time) begin
              mag = (spd_m < 0) ? -longint'(spd_m) : longint'(spd_m);
              q = (longint'(cfg_m.extra_low_time) + longint'(cfg_m.pulse_high_time))
                  * longint'(cfg_m.max_speed) / mag;
              lt = (q > longint'(cfg_m.pulse_high_time)) ?
                   q - longint'(cfg_m.pulse_high_time) : 64'sd0;
              if (lt > longint'(cfg_m.max_low_time)) lt = longint'(cfg_m.max_low_time);
              stamp_m = now;
              phase_m = PH_LOW;
              step_m = 1'b0;
              low_m = 16'(lt);
            end
          end
          PH_LOW: begin
            if (16'(now - stamp_m) > low_m) begin
              pos_m = (spd_m > 0) ? pos_m + 32'sd1 : pos_m - 32'sd1;
              phase_m = PH_IDLE;
              busy_m = 1'b0;
            end
          end
          default: begin
            phase_m = PH_IDLE;
            step_m = 1'b0;
            busy_m = 1'b0;
          end
        endcase
      end
    end
    r.dir = dir_m;
    r.step = step_m;
    r.position = pos_m;
    r.speed = spd_m;
    r.arrived = (spd_m == 0) && (pos_m == tgt);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // apb write, then read back
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    logic [31:0] want;
    want = (idx == REG_REVERSE) ? {31'd0, val[0]} : {16'd0, val};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_ACCEL:     cfg_m.accel_step = val;
      REG_MAX_SPEED: cfg_m.max_speed = val;
      REG_HIGH:      cfg_m.pulse_high_time = val;
      REG_EXTRA:     cfg_m.extra_low_time = val;
      REG_MAX_LOW:   cfg_m.max_low_time = val;
      REG_REVERSE:   cfg_m.reverse_direction = val[0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      mismatches++;
      $display("%0t: register %s expected %0h got %0h", $time, idx.name(), want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_ACCEL, c.accel_step);
    write_reg(REG_MAX_SPEED, c.max_speed);
    write_reg(REG_HIGH, c.pulse_high_time);
    write_reg(REG_EXTRA, c.extra_low_time);
    write_reg(REG_MAX_LOW, c.max_low_time);
    write_reg(REG_REVERSE, 16'(c.reverse_direction));
  endtask

  // present one poll word, wait for acceptance, record what should come back
  task automatic send_poll(input logic [15:0] now, input logic signed [31:0] tgt,
                           input logic zero, input logic typed, input motion_t typed_res);
    motion_t predicted;
    while (stall_on && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tgt, now};
    s_axis_tuser <= zero;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = advance_motion(now, tgt, zero);
    pending_motion.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk_i);
  endtask

  // result sink with random back-pressure
  always @(posedge clk_i) begin : sink
    motion_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[51:0];
      if (pending_motion.size() == 0) begin
        mismatches++;
        $display("%0t: result word with no poll pending, got %h", $time, got);
      end else begin
        want = pending_motion.pop_front();
        check_field("dir_level", want.dir, got.dir);
        check_field("step_level", want.step, got.step);
        check_field("position", want.position, got.position);
        check_field("speed", want.speed, got.speed);
        check_field("arrived", want.arrived, got.arrived);
      end
    end
    m_axis_tready <= !stall_on || ($urandom_range(0, 99) >= 22);
  end

  // watchdog: cycles with no word moving on either side and no apb access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    motion_t            none;
    logic [15:0]        now;
    logic signed [31:0] goal;
    logic signed [31:0] tgt;
    logic               zero;
    int                 goal_left;
    none = '0;
    goal = '0;
    goal_left = 0;
    cfg_m = '{ACCEL_RST, MAX_SPD_RST, HIGH_RST, EXTRA_RST, MAX_LOW_RST, REVERSE_RST};

    // at rest on target, then one full step from rest under reset settings
    poll_rows[0]  = '{16'd0,     32'sd0,  1'b0, 1'b1, '{1'b1, 17'sd0, 32'sd0, 1'b0, 1'b0}};
    poll_rows[1]  = '{16'd100,   32'sd5,  1'b0, 1'b1, '{1'b0, 17'sd1, 32'sd0, 1'b1, 1'b1}};
    poll_rows[2]  = '{16'd105,   32'sd5,  1'b0, 1'b1, '{1'b0, 17'sd1, 32'sd0, 1'b1, 1'b1}};
    poll_rows[3]  = '{16'd111,   32'sd5,  1'b0, 1'b1, '{1'b0, 17'sd1, 32'sd0, 1'b0, 1'b1}};
    poll_rows[4]  = '{16'd20101, 32'sd5,  1'b0, 1'b1, '{1'b0, 17'sd1, 32'sd0, 1'b0, 1'b1}};
    poll_rows[5]  = '{16'd20102, 32'sd5,  1'b0, 1'b1, '{1'b0, 17'sd1, 32'sd1, 1'b0, 1'b1}};
    // timer wrap, extreme targets, zeroing while moving
    poll_rows[6]  = '{16'd20103, 32'sd5,          1'b0, 1'b0, none};
    poll_rows[7]  = '{16'hFFFF,  32'sd5,          1'b0, 1'b0, none};
    poll_rows[8]  = '{16'd0,     32'sd5,          1'b0, 1'b0, none};
    poll_rows[9]  = '{16'd30,    32'h7FFFFFFF,    1'b0, 1'b0, none};
    poll_rows[10] = '{16'd60,    32'h7FFFFFFF,    1'b0, 1'b0, none};
    poll_rows[11] = '{16'd200,   32'h80000000,    1'b1, 1'b0, none};
    poll_rows[12] = '{16'd400,   32'h80000000,    1'b0, 1'b0, none};
    poll_rows[13] = '{16'hFFFF,  32'sd0,          1'b1, 1'b0, none};
    poll_rows[14] = '{16'd0,     32'sd0,          1'b1, 1'b0, none};
    poll_rows[15] = '{16'd12,    -32'sd3,         1'b0, 1'b0, none};
    poll_rows[16] = '{16'd30000, -32'sd3,         1'b0, 1'b0, none};
    poll_rows[17] = '{16'd65000, -32'sd3,         1'b0, 1'b0, none};
    poll_rows[18] = '{16'd1000,  -32'sd3,         1'b0, 1'b0, none};
    poll_rows[19] = '{16'hAAAA,  32'h55555555,    1'b0, 1'b0, none};
    poll_rows[20] = '{16'h5555,  32'hAAAAAAAA,    1'b1, 1'b0, none};

    // settings per random phase: accel, max speed, high, extra, max low, reverse
    phase_cfg[0] = '{16'd0,     16'd5,     16'd2,     16'd3,     16'd40,    1'b0};
    phase_cfg[1] = '{16'd3,     16'd20,    16'd1,     16'd5,     16'hFFFF,  1'b1};
    phase_cfg[2] = '{16'hFFFF,  16'hFFFF,  16'd0,     16'd0,     16'd0,     1'b1};
    // big carried-over speed against a small cap drives the low time to zero
    phase_cfg[3] = '{16'd30000, 16'd3,     16'd4,     16'd6,     16'd100,   1'b0};
    phase_cfg[4] = '{16'd1,     16'd1,     16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0};
    phase_cfg[5] = '{16'd1,     16'd8,     16'd3,     16'd2,     16'hFFFF,  1'b1};
    for (int p = 6; p < N_PHASES; p++) begin
      phase_cfg[p] = '{16'($urandom_range(1, 6)), 16'($urandom_range(1, 40)),
                       16'($urandom_range(0, 5)), 16'($urandom_range(0, 10)),
                       16'($urandom_range(0, 200)), 1'($urandom_range(0, 1))};
    end
    phase_len = '{90, 90, 60, 80, 20, 100, 100, 100};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset settings
    for (int i = 0; i < N_ROWS; i++) begin
      send_poll(poll_rows[i].now, poll_rows[i].target, poll_rows[i].zero,
                poll_rows[i].typed, poll_rows[i].res);
    end
    drain_results();

    // random phases: polls mostly chase nearby goals, with far targets and noise
    now = 16'd1000;
    for (int p = 0; p < N_PHASES; p++) begin
      apply_cfg(phase_cfg[p]);
      stall_on = (p != 5);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (goal_left == 0) begin
          goal_left = $urandom_range(5, 40);
          if ($urandom_range(0, 99) < 8)
            goal = $urandom;
          else
            goal = pos_m + int'($urandom_range(0, 60)) - 32'sd30;
        end
        goal_left--;
        if ($urandom_range(0, 49) == 0)
          now = 16'($urandom);
        else
          now = now + 16'($urandom_range(0, 12));
        tgt = ($urandom_range(0, 29) == 0) ? $urandom : goal;
        zero = ($urandom_range(0, 59) == 0);
        send_poll(now, tgt, zero, 1'b0, none);
      end
      drain_results();
    end

    stall_on = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_motion.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
